FILE: hdl/swsb_pkg.sv
// Package with the request and result types, table geometry and bucket limits.
`timescale 1ns / 1ps

package swsb_pkg;

  localparam int SQUARES       = 81;
  localparam int FEATURE_COUNT = 1548;
  localparam int DEPTH         = SQUARES * FEATURE_COUNT;
  localparam int ADDR_W        = $clog2(DEPTH);

  localparam int SQ_W   = 7;
  localparam int FT_W   = 11;
  localparam int WT_W   = 16;
  localparam int SUM_W  = 24;
  localparam int BKT_W  = 3;
  localparam int WIDE_W = SUM_W + 2;
  localparam int LIMITS = 7;

  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_FEATURE = 1'b1;

  localparam logic signed [WIDE_W-1:0] SUM_MAX = WIDE_W'(8388607);
  localparam logic signed [WIDE_W-1:0] SUM_MIN = -WIDE_W'(8388608);

  localparam logic signed [SUM_W-1:0] BUCKET_LIMIT [LIMITS] = '{
    -24'sd63764, -24'sd35999, -24'sd16739, 24'sd0,
    24'sd16739, 24'sd35999, 24'sd63764
  };

  typedef struct packed {
    logic                   req_type;
    logic [SQ_W-1:0]        weight_square;
    logic [FT_W-1:0]        weight_feature;
    logic signed [WT_W-1:0] weight_value;
    logic [SQ_W-1:0]        own_king_square;
    logic [SQ_W-1:0]        other_king_square;
    logic [FT_W-1:0]        own_piece;
    logic [FT_W-1:0]        other_piece;
    logic                   last;
  } in_req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] weighted_sum;
    logic [BKT_W-1:0]        progress_bucket;
  } out_res_t;

  function automatic logic [BKT_W-1:0] bucket_of(input logic signed [SUM_W-1:0] s);
    logic [BKT_W-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < LIMITS; i++) begin
      cnt = cnt + BKT_W'(s >= BUCKET_LIMIT[i]);
    end
    return cnt;
  endfunction

endpackage

FILE: hdl/sparse_weight_sum_bucketizer_top.sv
// Top level of the sparse weight-sum bucketizer: weight memory, accumulator and result stage.
`timescale 1ns / 1ps
//
// Requests arrive on in_valid/in_ready/in_data. A weight-write request stores one
// Q0.15 entry in the weight memory; a feature request reads two entries, one per
// side, and adds them to the running sum with saturation to 24 bits. A feature
// request marked last produces one result on out_valid/out_ready/out_data with the
// sum and its bucket, and clears the sum. Requests are taken one per cycle; the
// memory has one write port for write requests and two read ports for feature
// requests. The memory read registers at the edge that accepts a request; the sum
// then registers in the running sum or, for a last request, in the waiting result
// stage, and the bucket compare in the output register. When the receiver stalls,
// the output register and one waiting result stage hold results while requests
// without a result keep flowing; in_ready drops only when a further last request
// finds both full. Reset clears the running sum and all valid flags. The weight
// memory is not cleared; entries must be written before they are read.
//
module sparse_weight_sum_bucketizer_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  swsb_pkg::in_req_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output swsb_pkg::out_res_t out_data
);
  import swsb_pkg::*;

  logic signed [WT_W-1:0] mem [DEPTH];

  logic                    accept;
  logic                    wr_ok, a_ok, b_ok;
  logic [ADDR_W-1:0]       wr_addr, a_addr, b_addr;
  logic signed [WT_W-1:0]  rd_a_r, rd_b_r;

  logic s1_v_r, s1_v_nxt, s1_feat_r, s1_last_r, s1_a_en_r, s1_b_en_r;
  logic s1_done, s1_emit;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt, sat_sum;
  logic signed [WIDE_W-1:0] wide_sum;
  logic signed [WT_W-1:0]   a_w, b_w;

  logic                    s2_v_r, s2_v_nxt, s2_adv;
  logic signed [SUM_W-1:0] s2_sum_r;
  logic                    out_v_r, out_v_nxt, out_adv;
  out_res_t                out_r;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [SQ_W-1:0] sq,
                                                input logic [FT_W-1:0] ft);
    return ADDR_W'(ADDR_W'(sq) * ADDR_W'(FEATURE_COUNT) + ADDR_W'(ft));
  endfunction

  assign out_adv  = !out_v_r || out_ready;
  assign s2_adv   = !s2_v_r || out_adv;
  assign s1_emit  = s1_v_r && s1_feat_r && s1_last_r;
  assign s1_done  = s1_v_r && (!(s1_feat_r && s1_last_r) || s2_adv);
  assign in_ready = !s1_v_r || s1_done;
  assign accept   = in_valid && in_ready;

  assign wr_ok = (32'(in_data.weight_square) < SQUARES) &&
                 (32'(in_data.weight_feature) < FEATURE_COUNT);
  assign a_ok  = (32'(in_data.own_king_square) < SQUARES) &&
                 (32'(in_data.own_piece) < FEATURE_COUNT);
  assign b_ok  = (32'(in_data.other_king_square) < SQUARES) &&
                 (32'(in_data.other_piece) < FEATURE_COUNT);

  assign wr_addr = wr_ok ? addr_of(in_data.weight_square, in_data.weight_feature) : '0;
  assign a_addr  = a_ok ? addr_of(in_data.own_king_square, in_data.own_piece) : '0;
  assign b_addr  = b_ok ? addr_of(in_data.other_king_square, in_data.other_piece) : '0;

  always_ff @(posedge clk) begin
    if (accept && in_data.req_type == REQ_WRITE && wr_ok) begin
      mem[wr_addr] <= in_data.weight_value;
    end
    if (accept && in_data.req_type == REQ_FEATURE) begin
      rd_a_r <= mem[a_addr];
      rd_b_r <= mem[b_addr];
    end
  end

  always_comb begin
    a_w      = s1_a_en_r ? rd_a_r : '0;
    b_w      = s1_b_en_r ? rd_b_r : '0;
    wide_sum = WIDE_W'(sum_r) + WIDE_W'(a_w) + WIDE_W'(b_w);
    if (wide_sum > SUM_MAX) begin
      sat_sum = SUM_W'(SUM_MAX);
    end else if (wide_sum < SUM_MIN) begin
      sat_sum = SUM_W'(SUM_MIN);
    end else begin
      sat_sum = SUM_W'(wide_sum);
    end
    sum_nxt = sum_r;
    if (s1_done && s1_feat_r) begin
      sum_nxt = s1_last_r ? '0 : sat_sum;
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (s1_done) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_v_r;
    if (s1_done && s1_emit) begin
      s2_v_nxt = 1'b1;
    end else if (s2_v_r && out_adv) begin
      s2_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s2_v_r && out_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      sum_r   <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_feat_r <= in_data.req_type;
      s1_last_r <= in_data.last;
      s1_a_en_r <= a_ok;
      s1_b_en_r <= b_ok;
    end
    if (s1_done && s1_emit) begin
      s2_sum_r <= sat_sum;
    end
    if (s2_v_r && out_adv) begin
      out_r.weighted_sum    <= s2_sum_r;
      out_r.progress_bucket <= bucket_of(s2_sum_r);
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

FILE: hdl/swsb_checker.sv
// Port-level checker for the bucketizer top level and its bind statement.
`timescale 1ns / 1ps

module swsb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input swsb_pkg::in_req_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input swsb_pkg::out_res_t out_data
);
  import swsb_pkg::*;

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("Request channel blocked without an output stall.");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=> (in_valid && $stable(in_data)))
    else $error("Waiting request changed or dropped.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("Stalled result changed or dropped.");

  a_bucket_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.weighted_sum >= 0) == (out_data.progress_bucket >= 3'd4)))
    else $error("Bucket disagrees with the sign of the sum.");

endmodule

bind sparse_weight_sum_bucketizer_top swsb_checker u_swsb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
